// ===== sv/skewed_waveform_oscillator_macros.svh =====
// Assertion macros shared by the oscillator RTL.
`ifndef SKEWED_WAVEFORM_OSCILLATOR_MACROS_SVH
`define SKEWED_WAVEFORM_OSCILLATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SWO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skewed_waveform_oscillator: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SWO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skewed_waveform_oscillator: next-cycle check failed");

`endif

// ===== sv/swo_pkg.sv =====
// Types, constants and sine table builder for the skewed waveform oscillator.
`timescale 1ns / 1ps
package swo_pkg;

   localparam int SINE_DEPTH  = 1024;
   localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
   localparam int SAMPLE_W    = 16;
   localparam int ROM_W       = 16;

   localparam int WAVE_W      = 2;
   localparam int PHASE_W     = 32;
   localparam int MIDWAY_W    = 17;
   localparam int VOLUME_W    = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int MAG_W       = PHASE_W + 1;
   localparam int DEN_W       = PHASE_W + 1;
   localparam int NUM_W       = MAG_W + VOLUME_W;
   localparam int QUOT_W      = 31;
   localparam int DIV_STEPS   = QUOT_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam longint FULL_SCALE  = 32767;
   localparam longint HALF_PI_Q30 = 1686629713;
   localparam longint MIDWAY_ONE  = 65536;
   localparam longint PULSE_LEVEL = 32768;
   localparam logic [PHASE_W:0] PHASE_ONE = {1'b1, {PHASE_W{1'b0}}};

   localparam logic [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHAPE      = 2'd0,
      CSR_PHASE_STEP = 2'd1,
      CSR_MIDWAY     = 2'd2,
      CSR_VOLUME     = 2'd3
   } csr_index_type;

   typedef enum logic [WAVE_W-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_PULSE    = 2'd1,
      WAVE_TRIANGLE = 2'd2
   } wave_kind_type;

   typedef enum logic [1:0] {
      RES_DIV       = 2'd0,
      RES_MAX_CLIP  = 2'd1,
      RES_ZERO_CLIP = 2'd2,
      RES_ZERO      = 2'd3
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_PREP   = 3'd1,
      ST_MUL    = 3'd2,
      ST_START  = 3'd3,
      ST_WAIT   = 3'd4,
      ST_FINISH = 3'd5
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef logic [ROM_W-1:0] sine_rom_type [SINE_DEPTH];

   // Q2.30 Taylor series of sin up to x^13, rounded to full scale.
   function automatic logic [ROM_W-1:0] sine_entry(input longint k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] scaled;
      x = (64'(HALF_PI_Q30) * 64'(k)) / 64'(SINE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + signed'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      scaled = (unsigned'(sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      return scaled[ROM_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         rom[k] = sine_entry(longint'(k));
      end
      return rom;
   endfunction

endpackage

// ===== sv/swo_sine_rom.sv =====
// Quarter-wave sine table with mirrored addressing and registered read.
`timescale 1ns / 1ps
module swo_sine_rom (
   input  logic                            clock,
   input  logic [swo_pkg::SINE_ADDR_W-1:0] idx,
   input  logic                            mirror,
   output logic [swo_pkg::ROM_W-1:0]       data
);
   import swo_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [SINE_ADDR_W-1:0] addr;
   logic                   top;
   logic [ROM_W-1:0]       data_ff;

   // mirrored entry DEPTH - idx; idx zero there means the table end
   assign addr = mirror ? (~idx + 1'b1) : idx;
   assign top  = mirror && (idx == '0);

   always_ff @(posedge clock) begin
      data_ff <= top ? ROM_W'(FULL_SCALE) : SINE_ROM[addr];
   end

   assign data = data_ff;

endmodule

// ===== sv/swo_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module swo_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [swo_pkg::NUM_W-1:0]    num,
   input  logic [swo_pkg::DEN_W-1:0]    den,
   output swo_pkg::div_status_type      status,
   output logic [swo_pkg::QUOT_W-1:0]   quot
);
   import swo_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [QUOT_W-1:0]    low_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       trial;
   logic [DEN_W+1:0]     diff;
   logic                 borrow;

   assign trial  = {rem_ff, low_ff[QUOT_W-1]};
   assign diff   = {1'b0, trial} - {2'b00, den_ff};
   assign borrow = diff[DEN_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift quotient bits into the low half as the numerator bits leave it
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(num[NUM_W-1:QUOT_W]);
         low_ff <= num[QUOT_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
         low_ff <= {low_ff[QUOT_W-2:0], ~borrow};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = low_ff;

endmodule

// ===== sv/skewed_waveform_oscillator.sv =====
// Top level of the skewed waveform oscillator: registers, sequencer and datapath.
`timescale 1ns / 1ps
`include "skewed_waveform_oscillator_macros.svh"
// Direct digital synthesis oscillator. Each req transaction makes one signed
// sample from the 32-bit phase accumulator (zeroed first when req_restart is
// set) and then advances the phase by phase_step. The shape register picks
// sine (quarter-wave table), pulse (duty set by midway) or triangle (peak at
// midway); the unit wave is scaled by volume, truncated toward zero and
// saturated, and rsp_clipped marks saturation or a zero-width edge. A
// transaction steps through PREP, MUL, START, WAIT and FINISH, with WAIT
// covering the 31 steps of the shared restoring divider; the zero-width
// cases and shape code 3 skip the divider and go from PREP to FINISH.
// req_ready is high only while the sequencer is idle; a finished result
// waits in the rsp register; the next transaction starts but holds in FINISH
// until it is taken. CSR writes take effect at once and belong in idle periods.
module skewed_waveform_oscillator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [swo_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                               rsp_clipped,
   input  logic                               csr_wr_en,
   input  logic [swo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [swo_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import swo_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic             accept;
   logic             div_start;
   logic             load_rsp;

   wave_kind_type    shape_ff;
   logic [PHASE_W-1:0]  phase_step_ff;
   logic [MIDWAY_W-1:0] midway_ff;
   logic [VOLUME_W-1:0] volume_ff;

   logic [PHASE_W-1:0]  phase_acc_ff;
   logic [PHASE_W-1:0]  phase_ff;

   logic [MIDWAY_W-1:0] mid;
   logic [PHASE_W:0]    bigm;
   logic [PHASE_W-1:0]  tri_i;
   logic signed [PHASE_W+2:0] tri_t;
   result_kind_type     kind_in;
   logic [MAG_W-1:0]    mag_in;
   logic [DEN_W-1:0]    den_in;
   logic                neg_in;

   result_kind_type     kind_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic [DEN_W-1:0]    den_ff;
   logic                neg_ff;

   logic [ROM_W-1:0]    rom_data;
   logic [MAG_W-1:0]    oper;
   logic [NUM_W-1:0]    prod_ff;

   div_status_type      div_status;
   logic [QUOT_W-1:0]   quot;

   logic [SAMPLE_W-1:0] res_sample;
   logic                res_clip;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff;
   logic                rsp_clipped_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = (kind_in == RES_DIV) ? ST_MUL : ST_FINISH;
         end
         ST_MUL: begin
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff      <= WAVE_SINE;
         phase_step_ff <= '0;
         midway_ff     <= MIDWAY_W'(32768);
         volume_ff     <= VOLUME_W'(6553);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHAPE:      shape_ff      <= wave_kind_type'(csr_wdata[WAVE_W-1:0]);
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata[PHASE_W-1:0];
            CSR_MIDWAY:     midway_ff     <= csr_wdata[MIDWAY_W-1:0];
            CSR_VOLUME:     volume_ff     <= csr_wdata[VOLUME_W-1:0];
         endcase
      end
   end

   // phase accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else if (accept) begin
         phase_acc_ff <= (req_restart ? '0 : phase_acc_ff) + phase_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         phase_ff <= req_restart ? '0 : phase_acc_ff;
      end
   end

   // operand setup
   assign mid   = (midway_ff > MIDWAY_W'(MIDWAY_ONE)) ? MIDWAY_W'(MIDWAY_ONE) : midway_ff;
   assign bigm  = {mid, 16'b0};
   assign tri_i = phase_ff + {mid, 15'b0};

   always_comb begin
      kind_in = RES_DIV;
      mag_in  = '0;
      den_in  = '0;
      neg_in  = 1'b0;
      tri_t   = '0;
      unique case (shape_ff)
         WAVE_SINE: begin
            den_in = DEN_W'(FULL_SCALE);
            neg_in = phase_ff[PHASE_W-1];
         end
         WAVE_PULSE: begin
            if ((mid == '0) && (phase_ff == '0)) begin
               kind_in = RES_MAX_CLIP;
            end else if ({1'b0, phase_ff} <= bigm) begin
               mag_in = MAG_W'(PULSE_LEVEL);
               den_in = DEN_W'(mid);
            end else begin
               mag_in = MAG_W'(PULSE_LEVEL);
               den_in = DEN_W'(MIDWAY_ONE) - DEN_W'(mid);
               neg_in = 1'b1;
            end
         end
         WAVE_TRIANGLE: begin
            if ((mid == '0) && (tri_i == '0)) begin
               kind_in = RES_ZERO_CLIP;
            end else begin
               if ({1'b0, tri_i} <= bigm) begin
                  tri_t  = signed'({2'b00, tri_i, 1'b0}) - signed'({2'b00, bigm});
                  den_in = bigm;
               end else begin
                  tri_t  = signed'((PHASE_W+3)'(PHASE_ONE)) + signed'({2'b00, bigm})
                           - signed'({2'b00, tri_i, 1'b0});
                  den_in = DEN_W'(PHASE_ONE) - bigm;
               end
               neg_in = tri_t[PHASE_W+2];
               mag_in = tri_t[PHASE_W+2] ? MAG_W'(-tri_t) : MAG_W'(tri_t);
            end
         end
         default: begin
            kind_in = RES_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         kind_ff <= kind_in;
         mag_ff  <= mag_in;
         den_ff  <= den_in;
         neg_ff  <= neg_in;
      end
   end

   swo_sine_rom u_sine_rom (
      .clock  (clock),
      .idx    (phase_ff[PHASE_W-3 -: SINE_ADDR_W]),
      .mirror (phase_ff[PHASE_W-2]),
      .data   (rom_data)
   );

   // scale by volume
   assign oper = (shape_ff == WAVE_SINE) ? MAG_W'(rom_data) : mag_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= NUM_W'(volume_ff) * NUM_W'(oper);
      end
   end

   swo_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (prod_ff),
      .den    (den_ff),
      .status (div_status),
      .quot   (quot)
   );

   // sign and saturate
   always_comb begin
      res_sample = '0;
      res_clip   = 1'b0;
      unique case (kind_ff)
         RES_DIV: begin
            if (neg_ff) begin
               if (quot > QUOT_W'(SMIN)) begin
                  res_sample = SMIN;
                  res_clip   = 1'b1;
               end else begin
                  res_sample = SAMPLE_W'(0) - quot[SAMPLE_W-1:0];
               end
            end else begin
               if (quot > QUOT_W'(SMAX)) begin
                  res_sample = SMAX;
                  res_clip   = 1'b1;
               end else begin
                  res_sample = quot[SAMPLE_W-1:0];
               end
            end
         end
         RES_MAX_CLIP: begin
            res_sample = SMAX;
            res_clip   = 1'b1;
         end
         RES_ZERO_CLIP: begin
            res_clip = 1'b1;
         end
         RES_ZERO: begin
            res_clip = 1'b0;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sample_ff  <= res_sample;
         rsp_clipped_ff <= res_clip;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = signed'(rsp_sample_ff);
   assign rsp_clipped = rsp_clipped_ff;

   `SWO_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `SWO_ASSERT_NEXT(a_restart_phase, clock, reset, accept && req_restart && !csr_wr_en, phase_acc_ff == phase_step_ff)
   `SWO_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))
   `SWO_ASSERT_SAME(a_idle_div_quiet, clock, reset, state_ff == ST_IDLE, !div_status.busy)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the skewed waveform oscillator: directed table, random phases.
`timescale 1ns / 1ps
module tb;
   import swo_pkg::*;

   localparam logic [WAVE_W-1:0] WAVE_UNUSED = 2'd3;
   localparam longint SAMPLE_HI = 32767;
   localparam longint SAMPLE_LO = -32768;
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic clipped;
   } tone_type;

   typedef struct {
      logic load;
      logic [WAVE_W-1:0] wave;
      logic [31:0] step;
      logic [31:0] mid;
      logic [31:0] vol;
      logic restart;
      logic known;
      tone_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic rsp_clipped;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SHAPE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // oscillator copy kept by the testbench
   logic [WAVE_W-1:0] cfg_wave = WAVE_SINE;
   logic [PHASE_W-1:0] cfg_step = '0;
   logic [MIDWAY_W-1:0] cfg_midway = 17'd32768;
   logic [VOLUME_W-1:0] cfg_volume = 15'd6553;
   logic [PHASE_W-1:0] phase_now = '0;
   logic [ROM_W-1:0] quarter_wave [SINE_DEPTH];

   tone_type tone_queue [$];
   stim_row_type plan [$];

   int fail_count = 0;
   int checked = 0;
   int clipped_seen = 0;
   int restarts_sent = 0;
   int settings = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;
   logic [7:0] rx_tick = '0;

   always #5 clock = ~clock;

   skewed_waveform_oscillator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample(rsp_sample),
      .rsp_clipped(rsp_clipped),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Quarter sine entry: Q2.30 Taylor series to x^13, rounded to full scale.
   function automatic logic [ROM_W-1:0] sine_level(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint acc;
      x = (HALF_PI_Q30 * k) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / (2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > (64'sd1 <<< 30)) begin
         acc = 64'sd1 <<< 30;
      end
      return ROM_W'((acc * FULL_SCALE + (64'sd1 <<< 29)) >> 30);
   endfunction

   // Make the sample for one tick and advance the phase.
   function automatic tone_type next_tone(input logic restart);
      longint vol;
      longint mid;
      longint bigm;
      longint ph;
      longint idx;
      longint level;
      longint v;
      longint tri_pos;
      longint full_turn;
      logic [PHASE_W-1:0] tri_phase;
      logic clip;
      tone_type r;
      if (restart) begin
         phase_now = '0;
      end
      vol = cfg_volume;
      mid = cfg_midway;
      if (mid > MIDWAY_ONE) begin
         mid = MIDWAY_ONE;
      end
      bigm = mid << 16;
      ph = phase_now;
      full_turn = 64'sd1 <<< 32;
      v = 0;
      clip = 1'b0;
      case (cfg_wave)
         WAVE_SINE: begin
            idx = phase_now[29:20];
            if (phase_now[30]) begin
               idx = SINE_DEPTH - idx;
            end
            level = (idx < SINE_DEPTH) ? longint'(quarter_wave[idx]) : FULL_SCALE;
            v = (vol * level) / FULL_SCALE;
            if (phase_now[31]) begin
               v = -v;
            end
         end
         WAVE_PULSE: begin
            if (ph <= bigm) begin
               if (mid == 0) begin
                  v = SAMPLE_HI;
                  clip = 1'b1;
               end else begin
                  v = (vol * PULSE_LEVEL) / mid;
               end
            end else begin
               v = -((vol * PULSE_LEVEL) / (MIDWAY_ONE - mid));
            end
         end
         WAVE_TRIANGLE: begin
            tri_phase = phase_now + PHASE_W'(mid << 15);
            tri_pos = tri_phase;
            if (mid == 0 && tri_pos == 0) begin
               v = 0;
               clip = 1'b1;
            end else if (tri_pos <= bigm) begin
               v = (vol * (2 * tri_pos - bigm)) / bigm;
            end else begin
               v = (vol * (full_turn + bigm - 2 * tri_pos)) / (full_turn - bigm);
            end
         end
         default: begin
            v = 0;
         end
      endcase
      if (v > SAMPLE_HI) begin
         v = SAMPLE_HI;
         clip = 1'b1;
      end else if (v < SAMPLE_LO) begin
         v = SAMPLE_LO;
         clip = 1'b1;
      end
      r.sample = v[SAMPLE_W-1:0];
      r.clipped = clip;
      phase_now = phase_now + cfg_step;
      return r;
   endfunction

   task automatic add_row(input logic load, input logic [WAVE_W-1:0] wave,
                          input logic [31:0] step, input logic [31:0] mid,
                          input logic [31:0] vol, input logic restart,
                          input logic known, input int want_sample,
                          input logic want_clip);
      stim_row_type row;
      row.load = load;
      row.wave = wave;
      row.step = step;
      row.mid = mid;
      row.vol = vol;
      row.restart = restart;
      row.known = known;
      row.want.sample = want_sample[SAMPLE_W-1:0];
      row.want.clipped = want_clip;
      plan.push_back(row);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SHAPE: cfg_wave = data[WAVE_W-1:0];
         CSR_PHASE_STEP: cfg_step = data[PHASE_W-1:0];
         CSR_MIDWAY: cfg_midway = data[MIDWAY_W-1:0];
         CSR_VOLUME: cfg_volume = data[VOLUME_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_osc(input logic [WAVE_W-1:0] wave, input logic [31:0] step,
                              input logic [31:0] mid, input logic [31:0] vol);
      csr_write(CSR_SHAPE, {30'd0, wave});
      csr_write(CSR_PHASE_STEP, step);
      csr_write(CSR_MIDWAY, mid);
      csr_write(CSR_VOLUME, vol);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   // Drop valid and wait for every outstanding sample.
   task automatic settle();
      req_valid <= 1'b0;
      while (tone_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_tick(input logic restart, input logic known, input tone_type want);
      tone_type predicted;
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      predicted = next_tone(restart);
      tone_queue.push_back(known ? want : predicted);
      if (restart) begin
         restarts_sent++;
      end
   endtask

   // Result side: check each transaction, then pick the next ready value.
   always @(posedge clock) begin
      tone_type want;
      tone_type got;
      rx_tick <= rx_tick + 8'd1;
      if (!reset && rsp_valid && rsp_ready) begin
         got.sample = rsp_sample;
         got.clipped = rsp_clipped;
         checked++;
         if (got.clipped) begin
            clipped_seen++;
         end
         if (tone_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("tb: unexpected sample=%0d clipped=%0b", got.sample, got.clipped);
            end
         end else begin
            want = tone_queue.pop_front();
            if (want.sample !== got.sample || want.clipped !== got.clipped) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("tb: mismatch on sample %0d: exp %0d/%0b got %0d/%0b",
                           checked, want.sample, want.clipped, got.sample, got.clipped);
               end
            end
         end
      end
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_tick[7:6])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2'd2: rsp_ready <= (rx_tick[2:0] != 3'd0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: no progress for %0d cycles", idle_cycles);
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      tone_type none;
      logic [WAVE_W-1:0] wave;
      logic [31:0] step;
      logic [31:0] mid;
      logic [31:0] vol;
      int items;
      int burst_left;
      int gap;
      bit no_gaps;
      logic restart;
      none = '0;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         quarter_wave[k] = sine_level(k);
      end

      add_row(0, WAVE_SINE, 0, 0, 0, 0, 1, 0, 0);
      add_row(1, WAVE_SINE, 32'h4000_0000, 32768, 32767, 1, 1, 0, 0);
      add_row(0, WAVE_SINE, 0, 0, 0, 0, 1, 32767, 0);
      add_row(0, WAVE_SINE, 0, 0, 0, 0, 1, 0, 0);
      add_row(0, WAVE_SINE, 0, 0, 0, 0, 1, -32767, 0);
      add_row(1, WAVE_PULSE, 32'h8000_0000, 0, 32767, 1, 1, 32767, 1);
      add_row(0, WAVE_PULSE, 0, 0, 0, 0, 1, -16383, 0);
      add_row(1, WAVE_PULSE, 32'h8000_0000, 65536, 32767, 1, 1, 16383, 0);
      add_row(0, WAVE_PULSE, 0, 0, 0, 0, 1, 16383, 0);
      add_row(1, WAVE_PULSE, 32'h8000_0000, 1, 32767, 1, 1, 32767, 1);
      add_row(0, WAVE_PULSE, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, WAVE_PULSE, 32'h8000_0000, 32'h1_FFFF, 32767, 1, 1, 16383, 0);
      add_row(1, WAVE_TRIANGLE, 32'hFFFF_FFFF, 0, 32767, 1, 1, 0, 1);
      add_row(0, WAVE_TRIANGLE, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, WAVE_TRIANGLE, 32'h8000_0000, 65536, 32767, 1, 0, 0, 0);
      add_row(0, WAVE_TRIANGLE, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, WAVE_TRIANGLE, 32'h4000_0000, 32768, 32767, 1, 0, 0, 0);
      add_row(0, WAVE_TRIANGLE, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, WAVE_TRIANGLE, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, WAVE_TRIANGLE, 0, 0, 0, 0, 0, 0, 0);
      add_row(1, WAVE_UNUSED, 32'h1234_5678, 32768, 32767, 1, 1, 0, 0);
      add_row(0, WAVE_UNUSED, 0, 0, 0, 0, 1, 0, 0);
      add_row(1, WAVE_SINE, 32'h4000_0000, 32768, 0, 1, 1, 0, 0);
      add_row(0, WAVE_SINE, 0, 0, 0, 0, 1, 0, 0);
      add_row(1, WAVE_SINE, 32'h0765_4321, 32768, 32767, 0, 0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].load) begin
            settle();
            program_osc(plan[r].wave, plan[r].step, plan[r].mid, plan[r].vol);
         end
         send_tick(plan[r].restart, plan[r].known, plan[r].want);
      end

      burst_left = 0;
      for (int ph = 0; ph < 10; ph++) begin
         settle();
         wave = (ph < 9) ? WAVE_W'(ph % 3) : WAVE_UNUSED;
         case ($urandom_range(0, 5))
            0: step = 32'd0;
            1: step = 32'hFFFF_FFFF;
            2: step = $urandom_range(1, 32'h0010_0000);
            4: step = 32'h4000_0000 >> $urandom_range(0, 8);
            default: step = $urandom();
         endcase
         case ($urandom_range(0, 7))
            0: mid = 32'd0;
            1: mid = 32'd65536;
            2: mid = 32'd1;
            3: mid = 32'd65535;
            4: mid = $urandom();
            default: mid = $urandom_range(0, 65536);
         endcase
         case ($urandom_range(0, 4))
            0: vol = 32'd0;
            1: vol = 32'd32767;
            2: vol = $urandom();
            default: vol = $urandom_range(0, 32767);
         endcase
         program_osc(wave, step, mid, vol);
         items = (wave == WAVE_UNUSED) ? 30 : 90;
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < items; n++) begin
            if (n == 10 && (ph == 1 || ph == 6)) begin
               hold_request = 1'b1;
            end
            if (!no_gaps && burst_left == 0) begin
               gap = $urandom_range(1, 45);
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
               burst_left = $urandom_range(1, 10);
            end
            if (burst_left != 0) begin
               burst_left--;
            end
            restart = (n == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 15) == 0);
            send_tick(restart, 1'b0, none);
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d samples checked over %0d register settings, %0d restarts",
               checked, settings, restarts_sent);
      $display("tb: sine, pulse, triangle and unused wave, %0d clipped samples seen",
               clipped_seen);
      if (fail_count == 0 && tone_queue.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
